### src/bf_instruction_stepper_assert.svh
// assertion macros shared by the bf instruction stepper checker
// depends on nothing; included by the checker file only
`ifndef BF_INSTRUCTION_STEPPER_ASSERT_SVH
`define BF_INSTRUCTION_STEPPER_ASSERT_SVH

// same-cycle implication, held off during reset
`define BFIS_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BFIS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bfis_pkg.sv
// shared types and constants of the bf instruction stepper
// depends on nothing; used by every module of the block but bfis_ram
`default_nettype none

package bfis_pkg;

  // field widths fixed by the interface
  localparam int CHAR_W = 8;
  localparam int CELL_W = 32;
  localparam int LEN_W  = 13;
  localparam int LADR_W = 12;
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  // register map
  localparam logic [APB_AW-1:0] REG_ADDR_PROGRAM_LENGTH = 2'd0;

  // request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // program characters
  localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h3E;  // '>'
  localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h3C;  // '<'
  localparam logic [CHAR_W-1:0] CH_INC   = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_DEC   = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_OUT   = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] CH_IN    = 8'h2C;  // ','
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;  // ']'

  // request payload
  typedef struct packed {
    logic                     func;
    logic [LADR_W-1:0]        load_addr;
    logic [CHAR_W-1:0]        load_char;
    logic signed [CELL_W-1:0] in_value;
  } req_t;

  // result payload
  typedef struct packed {
    logic              out_valid;
    logic [CHAR_W-1:0] out_char;
    logic              took_input;
    logic              halted;
    logic [LEN_W-1:0]  next_pc;
  } rsp_t;

  // program memory read address source
  typedef enum logic [1:0] {
    PSEL_PC  = 2'd0,
    PSEL_FWD = 2'd1,
    PSEL_BWD = 2'd2
  } psel_t;

  // controller to datapath commands
  typedef struct packed {
    logic  clr_step;
    logic  latch_req;
    logic  load_wr;
    logic  exec;
    logic  fwd_step;
    logic  bwd_dec;
    logic  bwd_step;
    logic  pc_from_j;
    logic  pc_zero;
    psel_t prog_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic halted;
    logic open_skip;
    logic close_jump;
    logic fwd_done;
    logic j_zero;
    logic bwd_match;
  } sts_t;

endpackage

`default_nettype wire

### src/bf_instruction_stepper.sv
// top level of the bf instruction stepper: register port and submodules
// depends on bfis_pkg, bfis_ctrl, bfis_datapath, bfis_ram
//
// A request is taken when start is high and busy is low. A load request
// (func = 0) writes one program character and goes straight from idle
// to its result. A step request runs at most one instruction at the
// program counter: a plain instruction passes through the exec state
// before its result; '[' on a zero cell then scans forward, and ']'
// scans back to its matching '[', restarting at 0 when no match is found.
// Each scan reads the program memory one character at a time through its
// registered read port, an address state then a data state per character.
// A step while halted goes straight to its result. Every result is shown
// for exactly one cycle with done high and cannot be held off by the
// receiver. After reset the block is busy while it zeroes the tape, one
// cell per cycle; program_length can be written during that time. The user
// must keep PROG_DEPTH and TAPE_DEPTH powers of two; the block does not
// enforce this.
`default_nettype none

module bf_instruction_stepper #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfis_pkg::APB_AW-1:0]  paddr,
  input  logic [bfis_pkg::APB_DW-1:0]  pwdata,
  output logic [bfis_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         start,
  input  bfis_pkg::req_t               req,
  output logic                         busy,
  output logic                         done,
  output bfis_pkg::rsp_t               rsp
);
  import bfis_pkg::*;

  logic [LEN_W-1:0] program_length;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_ADDR_PROGRAM_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_wr) begin
      program_length <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr == REG_ADDR_PROGRAM_LENGTH) ? APB_DW'(program_length) : '0;

  // controller
  bfis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (req.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath
  bfis_datapath #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .program_length (program_length),
    .cmd            (cmd),
    .sts            (sts),
    .rsp            (rsp)
  );

endmodule

`default_nettype wire

### src/bfis_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing; holds the program store and the tape
`default_nettype none

module bfis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/bfis_ctrl.sv
// controller state machine of the bf instruction stepper
// depends on bfis_pkg; drives the datapath through cmd_t, reads sts_t
`default_nettype none

module bfis_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           func,
  input  bfis_pkg::sts_t sts,
  output bfis_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);
  import bfis_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_EXEC     = 8'b0000_0100,
    ST_FWD_ADDR = 8'b0000_1000,
    ST_FWD_DATA = 8'b0001_0000,
    ST_BWD_ADDR = 8'b0010_0000,
    ST_BWD_DATA = 8'b0100_0000,
    ST_RESP     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register; reset starts the tape clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.prog_sel = PSEL_PC;
        if (start) begin
          cmd.latch_req = 1'b1;
          if (func == FUNC_LOAD) begin
            cmd.load_wr = 1'b1;
            state_next  = ST_RESP;
          end else if (sts.halted) begin
            state_next = ST_RESP;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.open_skip) begin
          state_next = ST_FWD_ADDR;
        end else if (sts.close_jump) begin
          state_next = ST_BWD_ADDR;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_FWD_ADDR: begin
        cmd.prog_sel = PSEL_FWD;
        if (sts.fwd_done) begin
          cmd.pc_from_j = 1'b1;
          state_next    = ST_RESP;
        end else begin
          state_next = ST_FWD_DATA;
        end
      end
      ST_FWD_DATA: begin
        cmd.fwd_step = 1'b1;
        state_next   = ST_FWD_ADDR;
      end
      ST_BWD_ADDR: begin
        cmd.prog_sel = PSEL_BWD;
        if (sts.j_zero) begin
          // no matching open bracket: restart at the top
          cmd.pc_zero = 1'b1;
          state_next  = ST_RESP;
        end else begin
          cmd.bwd_dec = 1'b1;
          state_next  = ST_BWD_DATA;
        end
      end
      ST_BWD_DATA: begin
        if (sts.bwd_match) begin
          cmd.pc_from_j = 1'b1;
          state_next    = ST_RESP;
        end else begin
          cmd.bwd_step = 1'b1;
          state_next   = ST_BWD_ADDR;
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESP);

endmodule

`default_nettype wire

### src/bfis_datapath.sv
// datapath of the bf instruction stepper: program store, tape, pointers
// depends on bfis_pkg and bfis_ram; commanded by bfis_ctrl
`default_nettype none

module bfis_datapath #(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bfis_pkg::req_t              req,
  input  logic [bfis_pkg::LEN_W-1:0]  program_length,
  input  bfis_pkg::cmd_t              cmd,
  output bfis_pkg::sts_t              sts,
  output bfis_pkg::rsp_t              rsp
);
  import bfis_pkg::*;

  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int PCW = $clog2(PROG_DEPTH + 1);
  localparam int TAW = $clog2(TAPE_DEPTH);

  logic [PCW-1:0]    pc;
  logic [TAW-1:0]    tp;
  logic [PCW-1:0]    j;
  logic [PCW-1:0]    depth;
  logic [TAW-1:0]    clr_addr;
  logic [CELL_W-1:0] in_value;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              took_input;

  logic [PCW-1:0]    eff_len;
  logic              halted;
  logic [PAW-1:0]    prog_raddr;
  logic [CHAR_W-1:0] prog_q;
  logic              tape_we;
  logic [TAW-1:0]    tape_waddr;
  logic [CELL_W-1:0] tape_wdata;
  logic [CELL_W-1:0] cell_q;
  logic              cell_zero;

  // effective program length, saturated at the store depth
  always_comb begin
    if (32'(program_length) >= PROG_DEPTH) begin
      eff_len = PCW'(PROG_DEPTH);
    end else begin
      eff_len = PCW'(program_length);
    end
  end

  assign halted    = (pc >= eff_len);
  assign cell_zero = (cell_q == '0);

  // program store read address
  always_comb begin
    unique case (cmd.prog_sel)
      PSEL_PC:  prog_raddr = PAW'(pc);
      PSEL_FWD: prog_raddr = PAW'(j);
      PSEL_BWD: prog_raddr = PAW'(j - PCW'(1));
      default:  prog_raddr = PAW'(pc);
    endcase
  end

  bfis_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (PROG_DEPTH)
  ) u_prog_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (PAW'(req.load_addr)),
    .wdata (req.load_char),
    .raddr (prog_raddr),
    .rdata (prog_q)
  );

  // tape write: clearing pass or cell update
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = tp;
    tape_wdata = '0;
    if (cmd.clr_step) begin
      tape_we    = 1'b1;
      tape_waddr = clr_addr;
    end else if (cmd.exec) begin
      case (prog_q)
        CH_INC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_q + CELL_W'(1);
        end
        CH_DEC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_q - CELL_W'(1);
        end
        CH_IN: begin
          tape_we    = 1'b1;
          tape_wdata = in_value;
        end
        default: begin
          tape_we = 1'b0;
        end
      endcase
    end
  end

  bfis_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TAPE_DEPTH)
  ) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (tp),
    .rdata (cell_q)
  );

  // control registers: program counter, tape pointer, clear address
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      tp       <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + TAW'(1);
      end
      if (cmd.exec) begin
        case (prog_q)
          CH_RIGHT: begin
            tp <= (tp == TAW'(TAPE_DEPTH - 1)) ? '0 : tp + TAW'(1);
            pc <= pc + PCW'(1);
          end
          CH_LEFT: begin
            tp <= (tp == '0) ? TAW'(TAPE_DEPTH - 1) : tp - TAW'(1);
            pc <= pc + PCW'(1);
          end
          CH_OPEN: begin
            if (!cell_zero) begin
              pc <= pc + PCW'(1);
            end
          end
          CH_CLOSE: begin
            pc <= pc;
          end
          default: begin
            pc <= pc + PCW'(1);
          end
        endcase
      end else if (cmd.pc_from_j) begin
        pc <= j;
      end else if (cmd.pc_zero) begin
        pc <= '0;
      end
    end
  end

  // bracket scan index and nesting depth
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (prog_q == CH_CLOSE) begin
        j <= pc;
      end else begin
        j <= pc + PCW'(1);
      end
      depth <= PCW'(1);
    end else if (cmd.fwd_step) begin
      case (prog_q)
        CH_OPEN:  depth <= depth + PCW'(1);
        CH_CLOSE: depth <= depth - PCW'(1);
        default:  depth <= depth;
      endcase
      j <= j + PCW'(1);
    end else if (cmd.bwd_dec) begin
      j <= j - PCW'(1);
    end else if (cmd.bwd_step) begin
      case (prog_q)
        CH_OPEN:  depth <= depth - PCW'(1);
        CH_CLOSE: depth <= depth + PCW'(1);
        default:  depth <= depth;
      endcase
    end
  end

  // request value and result flags
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      in_value   <= req.in_value;
      out_valid  <= 1'b0;
      out_char   <= '0;
      took_input <= 1'b0;
    end else if (cmd.exec) begin
      if (prog_q == CH_OUT) begin
        out_valid <= 1'b1;
        out_char  <= cell_q[CHAR_W-1:0];
      end
      if (prog_q == CH_IN) begin
        took_input <= 1'b1;
      end
    end
  end

  // status to the controller
  assign sts.clear_last = (clr_addr == TAW'(TAPE_DEPTH - 1));
  assign sts.halted     = halted;
  assign sts.open_skip  = (prog_q == CH_OPEN) && cell_zero;
  assign sts.close_jump = (prog_q == CH_CLOSE);
  assign sts.fwd_done   = (depth == '0) || (j >= eff_len);
  assign sts.j_zero     = (j == '0);
  assign sts.bwd_match  = (prog_q == CH_OPEN) && (depth == PCW'(1));

  // result payload
  assign rsp.out_valid  = out_valid;
  assign rsp.out_char   = out_char;
  assign rsp.took_input = took_input;
  assign rsp.halted     = halted;
  assign rsp.next_pc    = LEN_W'(pc);

endmodule

`default_nettype wire

### src/bfis_checker.sv
// port-level checker for the bf instruction stepper, bound to the top level
// depends on bfis_pkg and bf_instruction_stepper_assert.svh
`default_nettype none
`include "bf_instruction_stepper_assert.svh"

module bfis_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input bfis_pkg::rsp_t rsp
);

  // a taken request keeps the block busy in the next cycle
  `BFIS_ASSERT_NEXT(a_req_busy, clk, rst, start && !busy, busy, "request taken but not busy")

  // a result is only shown while the request is still open
  `BFIS_ASSERT_SAME(a_done_busy, clk, rst, done, busy, "result shown while idle")

  // after a result the block is ready again
  `BFIS_ASSERT_NEXT(a_done_ready, clk, rst, done, !busy, "not ready after result")

  // one instruction cannot both print and read input
  `BFIS_ASSERT_SAME(a_one_op, clk, rst, done, !(rsp.out_valid && rsp.took_input), "print and input together")

endmodule

bind bf_instruction_stepper bfis_checker u_bfis_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench for bf_instruction_stepper: directed, random-program and long-program tests
// predicts every result with an in-bench interpreter; depends on bfis_pkg and the rtl

module testbench;
  import bfis_pkg::*;

  localparam int PROG_WORDS   = 4096;
  localparam int TAPE_WORDS   = 4096;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_WORDS   = 256;
  localparam int LONG_STEPS   = 100;
  localparam int CYCLE_LIMIT  = 8000000;
  localparam int MAX_REPORTS  = 10;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              start   = 1'b0;
  req_t              req     = '0;
  logic              busy;
  logic              done;
  rsp_t              rsp;

  // interpreter state mirrored by the bench
  logic [CHAR_W-1:0] prog_mem [PROG_WORDS];
  logic [CELL_W-1:0] tape_mem [TAPE_WORDS];
  logic [LEN_W-1:0]  interp_pc;
  logic [LADR_W-1:0] interp_tp;
  logic [LEN_W-1:0]  prog_len;

  rsp_t pending_rsp [$];
  int   idle_pct    = 0;
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   n_loads     = 0;
  int   n_steps     = 0;
  int   n_printed   = 0;
  int   n_inputs    = 0;
  int   n_halted    = 0;

  bf_instruction_stepper u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp)
  );

  // clock and cycle count
  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // interpreter: length in use, bracket matching and one request
  function automatic logic [LEN_W-1:0] active_len();
    return (prog_len > LEN_W'(PROG_WORDS)) ? LEN_W'(PROG_WORDS) : prog_len;
  endfunction

  function automatic logic [LEN_W-1:0] skip_forward(input logic [LEN_W-1:0] at,
                                                    input logic [LEN_W-1:0] len);
    int depth;
    logic [LEN_W-1:0] j;
    depth = 1;
    j = at + 1'b1;
    while (depth > 0 && j < len) begin
      if (prog_mem[j[LADR_W-1:0]] == CH_OPEN) depth++;
      else if (prog_mem[j[LADR_W-1:0]] == CH_CLOSE) depth--;
      j++;
    end
    return j;
  endfunction

  function automatic logic [LEN_W-1:0] seek_back(input logic [LEN_W-1:0] at);
    int depth;
    logic [LEN_W-1:0] j;
    depth = 1;
    j = at;
    while (j > 0) begin
      j--;
      if (prog_mem[j[LADR_W-1:0]] == CH_CLOSE) begin
        depth++;
      end else if (prog_mem[j[LADR_W-1:0]] == CH_OPEN) begin
        depth--;
        if (depth == 0) return j;
      end
    end
    return '0;
  endfunction

  function automatic rsp_t interpret(input req_t r);
    rsp_t o;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] next;
    o = '0;
    len = active_len();
    if (r.func == FUNC_LOAD) begin
      prog_mem[r.load_addr] = r.load_char;
    end else if (interp_pc < len) begin
      next = interp_pc + 1'b1;
      case (prog_mem[interp_pc[LADR_W-1:0]])
        CH_RIGHT: interp_tp = interp_tp + 1'b1;
        CH_LEFT:  interp_tp = interp_tp - 1'b1;
        CH_INC:   tape_mem[interp_tp] = tape_mem[interp_tp] + 1'b1;
        CH_DEC:   tape_mem[interp_tp] = tape_mem[interp_tp] - 1'b1;
        CH_OUT: begin
          o.out_valid = 1'b1;
          o.out_char  = tape_mem[interp_tp][CHAR_W-1:0];
        end
        CH_IN: begin
          o.took_input = 1'b1;
          tape_mem[interp_tp] = r.in_value;
        end
        CH_OPEN: begin
          if (tape_mem[interp_tp] == '0) next = skip_forward(interp_pc, len);
        end
        CH_CLOSE: next = seek_back(interp_pc);
        default: ;
      endcase
      interp_pc = next;
    end
    o.halted  = (interp_pc >= active_len());
    o.next_pc = interp_pc;
    return o;
  endfunction

  // random content
  function automatic logic [CHAR_W-1:0] pick_command();
    case ($urandom_range(5))
      0:       return CH_RIGHT;
      1:       return CH_LEFT;
      2:       return CH_INC;
      3:       return CH_DEC;
      4:       return CH_OUT;
      default: return CH_IN;
    endcase
  endfunction

  // mostly small values so loops end, plus the extremes
  function automatic logic [CELL_W-1:0] pick_cell_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom;
      default: return $urandom_range(3);
    endcase
  endfunction

  function automatic req_t load_req(input logic [LADR_W-1:0] addr,
                                    input logic [CHAR_W-1:0] ch);
    req_t r;
    r = '0;
    r.func      = FUNC_LOAD;
    r.load_addr = addr;
    r.load_char = ch;
    r.in_value  = $urandom;
    return r;
  endfunction

  function automatic req_t step_req_value(input logic [CELL_W-1:0] value);
    req_t r;
    r = '0;
    r.func      = FUNC_STEP;
    r.load_addr = LADR_W'($urandom);
    r.load_char = CHAR_W'($urandom);
    r.in_value  = value;
    return r;
  endfunction

  // send one request, with a random gap first; start stays high afterwards
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    pending_rsp = {pending_rsp, interpret(r)};
    if (r.func == FUNC_LOAD) n_loads++;
    else n_steps++;
  endtask

  // hold off until every expected result is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_length(input logic [LEN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_PROGRAM_LENGTH;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    prog_len = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== APB_DW'(value)) begin
      flag_failure($sformatf("program_length read back %0h, wrote %0h", prdata, value));
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // bring the counter back to 0 through close brackets
  task automatic rewind_counter();
    while (interp_pc != '0) begin
      send_request(load_req(interp_pc[LADR_W-1:0], CH_CLOSE));
      drain_results();
      write_length(interp_pc + 1'b1);
      send_request(step_req_value(pick_cell_value()));
    end
    drain_results();
  endtask

  // result checker
  always @(negedge clk) begin : check_results
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        flag_failure($sformatf("result with no request pending: pc=%0d", rsp.next_pc));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.out_valid !== want.out_valid || rsp.out_char !== want.out_char ||
            rsp.took_input !== want.took_input || rsp.halted !== want.halted ||
            rsp.next_pc !== want.next_pc) begin
          flag_failure($sformatf(
            "expected valid=%0b char=%02h took=%0b halted=%0b pc=%0d, got %0b %02h %0b %0b %0d",
            want.out_valid, want.out_char, want.took_input, want.halted, want.next_pc,
            rsp.out_valid, rsp.out_char, rsp.took_input, rsp.halted, rsp.next_pc));
        end
        if (want.out_valid) n_printed++;
        if (want.took_input) n_inputs++;
        if (want.halted) n_halted++;
      end
    end
  end

  // every command, both wraps, nested skip, loop exit, unmatched brackets, halted steps
  task automatic test_directed();
    logic [CHAR_W-1:0] code [$];
    code = '{CH_LEFT, CH_DEC, CH_OUT, CH_IN, CH_RIGHT, CH_OPEN, CH_OPEN, CH_CLOSE,
             CH_CLOSE, CH_INC, CH_OPEN, CH_DEC, CH_CLOSE, CH_CLOSE};
    idle_pct = 0;
    send_request(load_req(12'hFFF, 8'hFF));
    foreach (code[i]) send_request(load_req(LADR_W'(i), code[i]));
    drain_results();
    write_length(LEN_W'(code.size()));
    // last step lands on the unmatched close and restarts at 0
    repeat (12) send_request(step_req_value(32'h8000_0000));
    // open bracket at 0 with no match inside 13 characters halts the program
    send_request(load_req('0, CH_OPEN));
    drain_results();
    write_length(LEN_W'(13));
    send_request(step_req_value(32'h7FFF_FFFF));
    // length below the counter: step changes nothing
    drain_results();
    write_length(LEN_W'(5));
    send_request(step_req_value(pick_cell_value()));
    drain_results();
  endtask

  // short random programs, mostly with balanced loops
  task automatic run_episode(input int body_len, input int step_count);
    logic [CHAR_W-1:0] code [$];
    logic [CHAR_W-1:0] ch;
    int depth;
    int left;
    int roll;
    rewind_counter();
    depth = 0;
    for (int i = 0; i < body_len; i++) begin
      left = body_len - i;
      roll = $urandom_range(99);
      if (depth == left) begin
        ch = CH_CLOSE;
        depth--;
      end else if (roll < 14 && left > depth + 1) begin
        ch = CH_OPEN;
        depth++;
      end else if (roll < 26 && depth > 0) begin
        ch = CH_CLOSE;
        depth--;
      end else if (roll < 30) begin
        ch = CHAR_W'($urandom);
      end else begin
        ch = pick_command();
      end
      code = {code, ch};
    end
    // tail: restart loop, plain end, or a stray open bracket
    roll = $urandom_range(99);
    if (roll < 60) code = {code, CH_CLOSE};
    else if (roll >= 85) code[$urandom_range(code.size() - 1)] = CH_OPEN;
    foreach (code[i]) send_request(load_req(LADR_W'(i), code[i]));
    drain_results();
    write_length(LEN_W'(code.size()));
    for (int k = 0; k < step_count; k++) begin
      if ($urandom_range(9) == 0) begin
        send_request(load_req(LADR_W'($urandom_range(code.size() - 1)), CHAR_W'($urandom)));
      end else begin
        send_request(step_req_value(pick_cell_value()));
      end
    end
    drain_results();
  endtask

  task automatic test_random_programs();
    int first;
    int phase;
    first = n_loads + n_steps;
    phase = 0;
    while (n_loads + n_steps - first < RANDOM_ITEMS) begin
      case (phase % 4)
        1:       idle_pct = 88;
        2:       idle_pct = 15;
        default: idle_pct = 0;
      endcase
      if ($urandom_range(4) == 0) run_episode($urandom_range(25, 63), $urandom_range(16, 64));
      else run_episode($urandom_range(1, 24), $urandom_range(16, 64));
      phase++;
    end
  endtask

  // long straight program under lengths 0, the store depth and the largest value;
  // no brackets, so each step below the length moves the counter by one and it stays inside the loaded part
  task automatic test_long_program();
    logic [CHAR_W-1:0] ch;
    int roll;
    idle_pct = 0;
    rewind_counter();
    write_length('0);
    send_request(step_req_value(pick_cell_value()));
    for (int a = 0; a < LONG_WORDS; a++) begin
      roll = $urandom_range(99);
      if (roll < 10) ch = CHAR_W'($urandom_range(8'h7A, 8'h60));
      else ch = pick_command();
      send_request(load_req(LADR_W'(a), ch));
    end
    drain_results();
    write_length(LEN_W'(PROG_WORDS));
    idle_pct = 88;
    repeat (LONG_STEPS) send_request(step_req_value(pick_cell_value()));
    drain_results();
    write_length(13'h1FFF);
    idle_pct = 15;
    repeat (LONG_STEPS) send_request(step_req_value(pick_cell_value()));
    drain_results();
  endtask

  // main sequence
  initial begin
    for (int i = 0; i < PROG_WORDS; i++) prog_mem[i] = '0;
    for (int i = 0; i < TAPE_WORDS; i++) tape_mem[i] = '0;
    interp_pc = '0;
    interp_tp = '0;
    prog_len  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_programs();
    test_long_program();
    drain_results();
    repeat (16) @(posedge clk);
    $display("ran %0d loads and %0d steps over program lengths 0 to 8191", n_loads, n_steps);
    $display("results: %0d printed chars, %0d inputs taken, %0d halted, %0d failures",
             n_printed, n_inputs, n_halted, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
